// ===== src/fbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types, constants and codes of the frame repair block planner.
// ----------------------------------------------------------------------------
package fbp_pkg;

  // framing constants
  localparam int unsigned META_BYTES       = 16;
  localparam int unsigned DEFAULT_PAYLOAD  = 1446;
  localparam int unsigned HEADER_BYTES     = 26;
  localparam int unsigned REPAIR_SUB_BYTES = 11;
  localparam int unsigned MAX_SYMBOLS      = 256;
  localparam int unsigned PROTECT_K        = 16;

  // field widths
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned SYM_W      = 16;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned MIN_W      = 8;
  localparam int unsigned REP_W      = 9;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // symbol size derivation
  localparam int unsigned OVERHEAD = HEADER_BYTES + REPAIR_SUB_BYTES;
  localparam int unsigned DEF_SYM  =
    (DEFAULT_PAYLOAD > OVERHEAD) ? (DEFAULT_PAYLOAD - OVERHEAD) : 1;
  // default-mtu span reaches PROTECT_K symbols when len-1 is at least this
  localparam int unsigned JUMBO_SPAN_MIN = (PROTECT_K - 1) * DEF_SYM;

  // divider iteration count, one quotient bit per step
  localparam int unsigned DIV_STEPS = LEN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // per-mille rounding by reciprocal multiply
  localparam int unsigned PERMILLE       = 1000;
  localparam int unsigned ROUND_UP       = 999;
  localparam int unsigned OP_W           = 8;
  localparam int unsigned PROD_W         = 18;
  localparam int unsigned RECIP_SHIFT    = 28;
  localparam int unsigned PERMILLE_RECIP =
    ((1 << RECIP_SHIFT) + PERMILLE - 1) / PERMILLE;
  localparam int unsigned RECIP_W        = 19;
  localparam int unsigned QPROD_W        = PROD_W + RECIP_W;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROD,
    ST_QUOT,
    ST_GPROD,
    ST_GQUOT,
    ST_FINISH
  } fbp_state_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEC_ENABLED   = 3'd0,
    CFG_IDR_RATE      = 3'd1,
    CFG_P_RATE        = 3'd2,
    CFG_ENHANCE_RATE  = 3'd3,
    CFG_ENHANCE_SET   = 3'd4,
    CFG_MIN_REPAIR    = 3'd5,
    CFG_PACKET_BUDGET = 3'd6
  } fbp_cfg_idx_e;

  // frame classes
  typedef enum logic [CLS_W-1:0] {
    CLS_IDR     = 2'd0,
    CLS_ENHANCE = 2'd1,
    CLS_PRED    = 2'd2
  } fbp_class_e;

  // configuration register set
  typedef struct packed {
    logic                  fec_enabled;
    logic [RATE_W-1:0]     idr_rate;
    logic [RATE_W-1:0]     p_rate;
    logic [RATE_W-1:0]     enhance_rate;
    logic                  enhance_set;
    logic [MIN_W-1:0]      min_repair;
    logic [CFG_DATA_W-1:0] packet_budget;
  } fbp_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_prod;
    logic mul_quot;
    logic guard_sel;
    logic finish;
  } fbp_cmd_t;

endpackage

// ===== src/fbp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fbp_cfg_regs
// Configuration register file, written through its own transfer channel.
// ----------------------------------------------------------------------------
module fbp_cfg_regs
  import fbp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output fbp_cfg_t              cfg_o
);

  fbp_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (fbp_cfg_idx_e'(cfg_index_i))
        CFG_FEC_ENABLED:   cfg_d.fec_enabled   = cfg_data_i[0];
        CFG_IDR_RATE:      cfg_d.idr_rate      = cfg_data_i[RATE_W-1:0];
        CFG_P_RATE:        cfg_d.p_rate        = cfg_data_i[RATE_W-1:0];
        CFG_ENHANCE_RATE:  cfg_d.enhance_rate  = cfg_data_i[RATE_W-1:0];
        CFG_ENHANCE_SET:   cfg_d.enhance_set   = cfg_data_i[0];
        CFG_MIN_REPAIR:    cfg_d.min_repair    = cfg_data_i[MIN_W-1:0];
        CFG_PACKET_BUDGET: cfg_d.packet_budget = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q               <= '0;
      cfg_q.fec_enabled   <= 1'b1;
      cfg_q.packet_budget <= CFG_DATA_W'(DEFAULT_PAYLOAD);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/fbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbp_ctrl
// Sequencer for one frame descriptor: divide, two rounding passes, finish.
// ----------------------------------------------------------------------------
module fbp_ctrl
  import fbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fbp_cmd_t cmd_o
);

  fbp_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.mul_prod = 1'b1;
        state_d        = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.mul_quot = 1'b1;
        state_d        = ST_GPROD;
      end
      ST_GPROD: begin
        cmd_o.mul_prod  = 1'b1;
        cmd_o.guard_sel = 1'b1;
        state_d         = ST_GQUOT;
      end
      ST_GQUOT: begin
        cmd_o.mul_quot  = 1'b1;
        cmd_o.guard_sel = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/fbp_datapath.sv =====
// ----------------------------------------------------------------------------
// fbp_datapath
// Symbol divider, per-mille rounding unit, repair selection and counters.
// ----------------------------------------------------------------------------
module fbp_datapath
  import fbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbp_cmd_t           cmd_i,
  input  fbp_cfg_t           cfg_i,
  input  logic [LEN_W-1:0]   frame_length_i,
  input  logic               idr_flag_i,
  input  logic               enhance_flag_i,
  input  logic               override_valid_i,
  input  logic [SYM_W-1:0]   override_parity_i,
  output logic               malformed_o,
  output logic [CLS_W-1:0]   fec_class_o,
  output logic [SYM_W-1:0]   symbol_bytes_o,
  output logic [SYM_W-1:0]   source_count_o,
  output logic [REP_W-1:0]   repair_total_o,
  output logic [CNT_W-1:0]   block_number_o,
  output logic [CNT_W-1:0]   first_seq_o,
  output logic               oversize_o,
  output logic               guard_applied_o
);

  // captured descriptor
  logic [LEN_W-1:0]  len_q;
  logic              idr_q, enh_q, ovv_q;
  logic [SYM_W-1:0]  ovp_q;
  logic [SYM_W-1:0]  sym_q;

  // divider
  logic [LEN_W-1:0]  dq_q, dq_d;
  logic [SYM_W-1:0]  rem_q, rem_d;
  logic [SYM_W:0]    rem_sh;
  logic              rem_ge;

  // rounding unit
  logic [PROD_W-1:0] prod_q;
  logic [REP_W-1:0]  r0_q, gr_q;
  logic [OP_W-1:0]   mul_op;
  logic [QPROD_W-1:0] qprod;

  // counters
  logic [CNT_W-1:0]  block_q, seq_q;

  // output registers
  logic              malformed_q, oversize_q, guard_q;
  logic [CLS_W-1:0]  cls_out_q;
  logic [SYM_W-1:0]  sym_out_q, k_out_q;
  logic [REP_W-1:0]  rep_out_q;
  logic [CNT_W-1:0]  blk_out_q, seq_out_q;

  // symbol size from the packet budget, at least one byte
  logic [SYM_W-1:0]  sym_new;
  assign sym_new = (cfg_i.packet_budget > CFG_DATA_W'(OVERHEAD))
                 ? SYM_W'(cfg_i.packet_budget - CFG_DATA_W'(OVERHEAD))
                 : SYM_W'(1);

  // class and its rate
  logic              enh_eff;
  fbp_class_e        cls;
  logic [RATE_W-1:0] rate;
  assign enh_eff = enh_q & ~idr_q;
  assign cls     = idr_q ? CLS_IDR : (enh_eff ? CLS_ENHANCE : CLS_PRED);

  always_comb begin
    case (cls)
      CLS_IDR:     rate = cfg_i.idr_rate;
      CLS_ENHANCE: rate = cfg_i.enhance_set ? cfg_i.enhance_rate : cfg_i.p_rate;
      default:     rate = cfg_i.p_rate;
    endcase
  end

  // source count from the quotient
  logic              k_big;
  logic [SYM_W-1:0]  k;
  logic              k_small;
  assign k_big   = (dq_q[LEN_W-1:SYM_W] != '0) || (dq_q[SYM_W-1:0] == '1);
  assign k       = dq_q[SYM_W-1:0] + 1'b1;
  assign k_small = (k < SYM_W'(MAX_SYMBOLS));

  // restoring divider step
  assign rem_sh = {rem_q, dq_q[LEN_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, sym_q});

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      dq_d  = frame_length_i - 1'b1;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      dq_d  = {dq_q[LEN_W-2:0], rem_ge};
      rem_d = rem_ge ? SYM_W'(rem_sh - {1'b0, sym_q}) : rem_sh[SYM_W-1:0];
    end
  end

  // ceil(op * rate / 1000) via reciprocal multiply
  assign mul_op = cmd_i.guard_sel ? OP_W'(PROTECT_K) : k[OP_W-1:0];
  assign qprod  = QPROD_W'(prod_q) * QPROD_W'(PERMILLE_RECIP);

  // repair selection
  logic              fec_on, rate_on;
  logic [REP_W-1:0]  rmin, gmin, cap, r_rate, r_ovr, r_fin;
  logic [REP_W:0]    k_plus_r;
  logic              ovs_hit, ovr_use, jumbo, guard_hit, malformed;
  logic [LEN_W-1:0]  len_m1;

  assign fec_on   = cfg_i.fec_enabled;
  assign rate_on  = fec_on && (rate != '0);
  assign rmin     = (r0_q < REP_W'(cfg_i.min_repair)) ? REP_W'(cfg_i.min_repair) : r0_q;
  assign gmin     = (gr_q < REP_W'(cfg_i.min_repair)) ? REP_W'(cfg_i.min_repair) : gr_q;
  assign k_plus_r = (REP_W+1)'(k[OP_W-1:0]) + (REP_W+1)'(rmin);
  assign ovs_hit  = !k_small || (k_plus_r > (REP_W+1)'(MAX_SYMBOLS));
  assign cap      = k_small ? REP_W'(REP_W'(MAX_SYMBOLS) - REP_W'(k[OP_W-1:0])) : '0;
  assign r_rate   = (rate_on && !ovs_hit) ? rmin : '0;
  assign ovr_use  = ovv_q && !enh_eff && fec_on;
  assign r_ovr    = ovr_use ? ((ovp_q < SYM_W'(cap)) ? REP_W'(ovp_q) : cap) : r_rate;
  assign len_m1   = len_q - 1'b1;
  assign jumbo    = fec_on && (sym_q > SYM_W'(DEF_SYM)) && (k < SYM_W'(PROTECT_K))
                 && (len_m1 >= LEN_W'(JUMBO_SPAN_MIN));
  assign guard_hit = jumbo && (rate != '0) && (gmin <= cap) && (r_ovr < gmin);
  assign r_fin    = guard_hit ? gmin : r_ovr;
  assign malformed = (len_q < LEN_W'(META_BYTES)) || k_big;

  // descriptor capture, divider and rounding registers
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      len_q <= frame_length_i;
      idr_q <= idr_flag_i;
      enh_q <= enhance_flag_i;
      ovv_q <= override_valid_i;
      ovp_q <= override_parity_i;
      sym_q <= sym_new;
    end
    if (cmd_i.mul_prod) begin
      prod_q <= PROD_W'(PROD_W'(mul_op) * PROD_W'(rate)) + PROD_W'(ROUND_UP);
    end
    if (cmd_i.mul_quot) begin
      if (cmd_i.guard_sel) begin
        gr_q <= qprod[RECIP_SHIFT+REP_W-1:RECIP_SHIFT];
      end else begin
        r0_q <= qprod[RECIP_SHIFT+REP_W-1:RECIP_SHIFT];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (malformed) begin
        malformed_q <= 1'b1;
        cls_out_q   <= '0;
        sym_out_q   <= '0;
        k_out_q     <= '0;
        rep_out_q   <= '0;
        blk_out_q   <= '0;
        seq_out_q   <= '0;
        oversize_q  <= 1'b0;
        guard_q     <= 1'b0;
      end else begin
        malformed_q <= 1'b0;
        cls_out_q   <= cls;
        sym_out_q   <= sym_q;
        k_out_q     <= k;
        rep_out_q   <= r_fin;
        blk_out_q   <= block_q;
        seq_out_q   <= seq_q;
        oversize_q  <= rate_on && ovs_hit;
        guard_q     <= guard_hit;
      end
    end
  end

  // block and sequence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q <= '0;
      seq_q   <= '0;
    end else if (cmd_i.finish && !malformed) begin
      block_q <= block_q + 1'b1;
      seq_q   <= seq_q + CNT_W'(k) + CNT_W'(r_fin);
    end
  end

  assign malformed_o     = malformed_q;
  assign fec_class_o     = cls_out_q;
  assign symbol_bytes_o  = sym_out_q;
  assign source_count_o  = k_out_q;
  assign repair_total_o  = rep_out_q;
  assign block_number_o  = blk_out_q;
  assign first_seq_o     = seq_out_q;
  assign oversize_o      = oversize_q;
  assign guard_applied_o = guard_q;

endmodule

// ===== src/fec_block_planner_unit.sv =====
// ----------------------------------------------------------------------------
// fec_block_planner_unit
// Splits a frame into source symbols and plans its repair symbol count.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  in       in_valid_i / in_ready_o    frame_length, idr/enhance flags, override
//  out      out_valid_o / out_ready_i  malformed .. guard_applied
//  cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// an item passes from its transfer to its result through the one-bit restoring
// divider over all 24 quotient bits, two multiply passes each for the rate and
// the guard rounding, and the finish state
// the next item is taken only in the idle state after the finish state, so no
// new item is accepted while another is still being planned
// reset sets the default register values and clears both counters; no sweep
// a stalled output holds the finish cycle until the result register frees
// ----------------------------------------------------------------------------
module fec_block_planner_unit
  import fbp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LEN_W-1:0]      frame_length_i,
  input  logic                  idr_flag_i,
  input  logic                  enhance_flag_i,
  input  logic                  override_valid_i,
  input  logic [SYM_W-1:0]      override_parity_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  malformed_o,
  output logic [CLS_W-1:0]      fec_class_o,
  output logic [SYM_W-1:0]      symbol_bytes_o,
  output logic [SYM_W-1:0]      source_count_o,
  output logic [REP_W-1:0]      repair_total_o,
  output logic [CNT_W-1:0]      block_number_o,
  output logic [CNT_W-1:0]      first_seq_o,
  output logic                  oversize_o,
  output logic                  guard_applied_o
);

  fbp_cfg_t cfg;
  fbp_cmd_t cmd;

  // configuration registers
  fbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer
  fbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  fbp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .frame_length_i    (frame_length_i),
    .idr_flag_i        (idr_flag_i),
    .enhance_flag_i    (enhance_flag_i),
    .override_valid_i  (override_valid_i),
    .override_parity_i (override_parity_i),
    .malformed_o       (malformed_o),
    .fec_class_o       (fec_class_o),
    .symbol_bytes_o    (symbol_bytes_o),
    .source_count_o    (source_count_o),
    .repair_total_o    (repair_total_o),
    .block_number_o    (block_number_o),
    .first_seq_o       (first_seq_o),
    .oversize_o        (oversize_o),
    .guard_applied_o   (guard_applied_o)
  );

endmodule

// ===== verif/tb_fec_block_planner_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fec_block_planner_unit
// Self-checking bench for the frame repair block planner. A short list of
// directed frames over fixed register settings comes first, with hand-worked
// results for the simple rows. Random register settings and random frame
// descriptors follow. Every other result is compared against a behavioural plan of
// the frame, with bursty input traffic and a stalling output consumer.
// ----------------------------------------------------------------------------
module tb_fec_block_planner_unit;
  import fbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_PHASES        = 12;
  localparam int unsigned ITEMS_PER_PHASE = 134;
  localparam int unsigned SETTLE_CYCLES   = 45;
  localparam int unsigned STUCK_LIMIT     = 4000;
  localparam int unsigned DEF_SYM_BYTES   =
    DEFAULT_PAYLOAD - HEADER_BYTES - REPAIR_SUB_BYTES;
  localparam logic [LEN_W-1:0] LEN_MAX    = '1;
  localparam logic [SYM_W-1:0] PARITY_MAX = '1;

  // one frame descriptor
  typedef struct {
    logic [LEN_W-1:0] len;
    logic             idr;
    logic             enh;
    logic             ov_valid;
    logic [SYM_W-1:0] ovr_count;
  } frame_t;

  // one planned block
  typedef struct packed {
    logic             malformed;
    fbp_class_e       cls;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] src;
    logic [REP_W-1:0] rep;
    logic [CNT_W-1:0] blk;
    logic [CNT_W-1:0] seq;
    logic             oversize;
    logic             guard;
  } plan_t;

  // directed stimulus row
  typedef struct {
    int     prof;
    frame_t f;
    bit     typed;
    plan_t  want;
  } dir_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic [LEN_W-1:0]      frame_length    = '0;
  logic                  idr_flag        = 1'b0;
  logic                  enhance_flag    = 1'b0;
  logic                  override_valid  = 1'b0;
  logic [SYM_W-1:0]      override_parity = '0;
  logic                  out_ready       = 1'b0;

  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  malformed_o;
  logic [CLS_W-1:0]      fec_class_o;
  logic [SYM_W-1:0]      symbol_bytes_o;
  logic [SYM_W-1:0]      source_count_o;
  logic [REP_W-1:0]      repair_total_o;
  logic [CNT_W-1:0]      block_number_o;
  logic [CNT_W-1:0]      first_seq_o;
  logic                  oversize_o;
  logic                  guard_applied_o;

  fec_block_planner_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .frame_length_i   (frame_length),
    .idr_flag_i       (idr_flag),
    .enhance_flag_i   (enhance_flag),
    .override_valid_i (override_valid),
    .override_parity_i(override_parity),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .malformed_o      (malformed_o),
    .fec_class_o      (fec_class_o),
    .symbol_bytes_o   (symbol_bytes_o),
    .source_count_o   (source_count_o),
    .repair_total_o   (repair_total_o),
    .block_number_o   (block_number_o),
    .first_seq_o      (first_seq_o),
    .oversize_o       (oversize_o),
    .guard_applied_o  (guard_applied_o)
  );

  always #5 clk_i = ~clk_i;

  // planner state mirrored by the bench
  fbp_cfg_t         cur_cfg;
  logic [CNT_W-1:0] blocks_issued;
  logic [CNT_W-1:0] next_seq;
  plan_t            outstanding_plans[$];
  dir_row_t         directed_rows[$];
  fbp_cfg_t         profiles[6];

  int n_errors   = 0;
  int n_frames   = 0;
  int n_settings = 0;
  int n_malformed, n_oversize, n_guard, n_override;
  int burst_left = 1;

  function automatic fbp_cfg_t settings(logic en, int unsigned idr, int unsigned p,
                                        int unsigned enh, logic set, int unsigned minr,
                                        int unsigned budget);
    fbp_cfg_t c;
    c.fec_enabled   = en;
    c.idr_rate      = idr[RATE_W-1:0];
    c.p_rate        = p[RATE_W-1:0];
    c.enhance_rate  = enh[RATE_W-1:0];
    c.enhance_set   = set;
    c.min_repair    = minr[MIN_W-1:0];
    c.packet_budget = budget[CFG_DATA_W-1:0];
    return c;
  endfunction

  function automatic plan_t typed_plan(logic mal, fbp_class_e c, int unsigned sym,
                                       int unsigned src, int unsigned rep,
                                       int unsigned blk, int unsigned seq);
    plan_t p;
    p           = '0;
    p.malformed = mal;
    p.cls       = c;
    p.sym       = sym[SYM_W-1:0];
    p.src       = src[SYM_W-1:0];
    p.rep       = rep[REP_W-1:0];
    p.blk       = blk;
    p.seq       = seq;
    return p;
  endfunction

  function automatic int unsigned sym_from_budget(logic [CFG_DATA_W-1:0] budget);
    return (budget > HEADER_BYTES + REPAIR_SUB_BYTES) ?
      budget - HEADER_BYTES - REPAIR_SUB_BYTES : 1;
  endfunction

  function automatic int unsigned rate_for_class(fbp_class_e c);
    case (c)
      CLS_IDR:     return cur_cfg.idr_rate;
      CLS_ENHANCE: return cur_cfg.enhance_set ? cur_cfg.enhance_rate : cur_cfg.p_rate;
      default:     return cur_cfg.p_rate;
    endcase
  endfunction

  // works out the block plan of one frame and, unless it is malformed, advances both counters
  function automatic plan_t plan_frame(frame_t f);
    plan_t       p;
    int unsigned s, dsym, k, dk, r, rate, cap, gr;
    logic        enh_eff, jumbo, en;
    p       = '0;
    en      = cur_cfg.fec_enabled;
    enh_eff = f.enh && !f.idr;
    if (f.len < META_BYTES) begin
      p.malformed = 1'b1;
      return p;
    end
    s = sym_from_budget(cur_cfg.packet_budget);
    k = 1 + (f.len - 1) / s;
    if (k > 32'hFFFF) begin
      p.malformed = 1'b1;
      return p;
    end
    // span the same frame would have at the default mtu
    dsym  = (DEF_SYM_BYTES > s) ? s : DEF_SYM_BYTES;
    dk    = 1 + (f.len - 1) / dsym;
    jumbo = en && s > dsym && k < PROTECT_K && dk >= PROTECT_K;
    p.cls = f.idr ? CLS_IDR : (enh_eff ? CLS_ENHANCE : CLS_PRED);
    rate  = rate_for_class(p.cls);
    cap   = (k < MAX_SYMBOLS) ? MAX_SYMBOLS - k : 0;
    // rate-derived count, dropped when the block would overflow
    r = 0;
    if (en && rate != 0) begin
      r = (k * rate + 999) / 1000;
      if (r < cur_cfg.min_repair) r = cur_cfg.min_repair;
      if (r != 0 && k + r > MAX_SYMBOLS) begin
        p.oversize = 1'b1;
        r          = 0;
      end
    end
    // one-shot override, never on enhance frames
    if (f.ov_valid && !enh_eff && en) r = (f.ovr_count < cap) ? f.ovr_count : cap;
    // jumbo guard lifts the count to default-mtu depth
    if (jumbo) begin
      gr = (PROTECT_K * rate + 999) / 1000;
      if (gr < cur_cfg.min_repair) gr = cur_cfg.min_repair;
      if (rate != 0 && gr <= cap && r < gr) begin
        r       = gr;
        p.guard = 1'b1;
      end
    end
    p.sym         = s[SYM_W-1:0];
    p.src         = k[SYM_W-1:0];
    p.rep         = r[REP_W-1:0];
    p.blk         = blocks_issued;
    p.seq         = next_seq;
    blocks_issued = blocks_issued + 1;
    next_seq      = next_seq + k + r;
    return p;
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1000;
      2:       return 1023;
      3:       return $urandom_range(1, 10);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic fbp_cfg_t random_settings();
    int unsigned minr, budget;
    case ($urandom_range(0, 3))
      0:       minr = 0;
      1:       minr = 255;
      2:       minr = $urandom_range(0, 8);
      default: minr = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    budget = 1446;
      2, 3:    budget = $urandom_range(1447, 9446);
      4:       budget = $urandom_range(58, 1445);
      5:       budget = $urandom_range(0, 57);
      6:       budget = $urandom_range(0, 1) ? 65535 : 58;
      default: budget = $urandom_range(0, 65535);
    endcase
    return settings($urandom_range(0, 4) != 0, pick_rate(), pick_rate(), pick_rate(),
                    $urandom_range(0, 1), minr, budget);
  endfunction

  // frame lengths aimed at the capacity and guard boundaries, with short and random ones mixed in
  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned s, k, len, pick;
    s    = sym_from_budget(cur_cfg.packet_budget);
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      len = $urandom_range(0, META_BYTES - 1);
    end else if (pick < 12) begin
      k   = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 300);
      len = (k - 1) * s + $urandom_range(1, s);
      if (len > LEN_MAX) len = LEN_MAX;
      if (len < META_BYTES) len = META_BYTES + $urandom_range(0, 3);
    end else if (pick < 15) begin
      len = $urandom_range(14 * DEF_SYM_BYTES, 17 * DEF_SYM_BYTES);
    end else begin
      len = $urandom;
    end
    f.len       = len[LEN_W-1:0];
    f.idr       = ($urandom_range(0, 3) == 0);
    f.enh       = ($urandom_range(0, 2) == 0);
    f.ov_valid  = ($urandom_range(0, 3) == 0);
    f.ovr_count = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    return f;
  endfunction

  task automatic add_row(int prof, int unsigned len, logic idr, logic enh, logic ovv,
                         int unsigned ovp, bit typed, plan_t want);
    dir_row_t row;
    row.prof        = prof;
    row.f.len       = len[LEN_W-1:0];
    row.f.idr       = idr;
    row.f.enh       = enh;
    row.f.ov_valid  = ovv;
    row.f.ovr_count = ovp[SYM_W-1:0];
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endtask

  // hold the input side until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding_plans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all registers in one run of transfers
  task automatic apply_settings(fbp_cfg_t c);
    fbp_cfg_idx_e          idx;
    logic [CFG_DATA_W-1:0] d;
    idx = CFG_FEC_ENABLED;
    cfg_valid <= 1'b1;
    for (int i = 0; i < idx.num(); i++) begin
      // bits above the register width are junk and must be dropped
      d = 16'($urandom);
      case (idx)
        CFG_FEC_ENABLED:  d[0]          = c.fec_enabled;
        CFG_IDR_RATE:     d[RATE_W-1:0] = c.idr_rate;
        CFG_P_RATE:       d[RATE_W-1:0] = c.p_rate;
        CFG_ENHANCE_RATE: d[RATE_W-1:0] = c.enhance_rate;
        CFG_ENHANCE_SET:  d[0]          = c.enhance_set;
        CFG_MIN_REPAIR:   d[MIN_W-1:0]  = c.min_repair;
        default:          d             = c.packet_budget;
      endcase
      cfg_index <= idx;
      cfg_data  <= d;
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  // offers one frame, records its plan on transfer, then maybe idles
  task automatic push_frame(frame_t f, bit typed, plan_t want);
    plan_t predicted;
    in_valid        <= 1'b1;
    frame_length    <= f.len;
    idr_flag        <= f.idr;
    enhance_flag    <= f.enh;
    override_valid  <= f.ov_valid;
    override_parity <= f.ovr_count;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = plan_frame(f);
    outstanding_plans.push_back(typed ? want : predicted);
    n_frames++;
    if (f.ov_valid) n_override++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // output consumer: always ready, random, or long stall windows
  int rx_mode, rx_mode_left, rx_phase_left;
  bit rx_stalled;
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      default: begin
        if (rx_phase_left == 0) begin
          rx_stalled    = !rx_stalled;
          rx_phase_left = rx_stalled ? $urandom_range(1, 25) : $urandom_range(1, 8);
        end else begin
          rx_phase_left--;
        end
        out_ready <= !rx_stalled;
      end
    endcase
  end

  // result checking against the oldest outstanding plan
  always @(posedge clk_i) begin : check_results
    plan_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (outstanding_plans.size() == 0) begin
        $error("result transfer with no frame outstanding");
        n_errors++;
      end else begin
        want = outstanding_plans.pop_front();
        check_field("malformed", want.malformed, malformed_o);
        check_field("fec_class", want.cls, fec_class_o);
        check_field("symbol_bytes", want.sym, symbol_bytes_o);
        check_field("source_count", want.src, source_count_o);
        check_field("repair_total", want.rep, repair_total_o);
        check_field("block_number", want.blk, block_number_o);
        check_field("first_seq", want.seq, first_seq_o);
        check_field("oversize", want.oversize, oversize_o);
        check_field("guard_applied", want.guard, guard_applied_o);
        if (malformed_o === 1'b1) n_malformed++;
        if (oversize_o === 1'b1) n_oversize++;
        if (guard_applied_o === 1'b1) n_guard++;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb_fec_block_planner_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    int cur_prof;
    n_malformed = 0;
    n_oversize  = 0;
    n_guard     = 0;
    n_override  = 0;

    // register sets for the directed rows; set 0 is the reset state
    profiles[0] = settings(1'b1, 0, 0, 0, 1'b0, 0, 1446);
    profiles[1] = settings(1'b1, 1000, 1, 1023, 1'b1, 0, 1446);
    profiles[2] = settings(1'b1, 500, 100, 50, 1'b0, 0, 9000);
    profiles[3] = settings(1'b0, 1000, 1000, 1000, 1'b1, 255, 58);
    profiles[4] = settings(1'b1, 0, 1023, 0, 1'b1, 255, 0);
    profiles[5] = settings(1'b1, 1000, 1000, 1000, 1'b0, 1, 65535);

    // reset values: short frames, class priority, one- and two-symbol frames
    add_row(0, 0, 0, 0, 0, 0, 1, typed_plan(1, CLS_IDR, 0, 0, 0, 0, 0));
    add_row(0, META_BYTES - 1, 1, 1, 1, PARITY_MAX, 1, typed_plan(1, CLS_IDR, 0, 0, 0, 0, 0));
    add_row(0, META_BYTES, 0, 0, 0, 0, 1, typed_plan(0, CLS_PRED, DEF_SYM_BYTES, 1, 0, 0, 0));
    add_row(0, META_BYTES, 1, 1, 0, 0, 1, typed_plan(0, CLS_IDR, DEF_SYM_BYTES, 1, 0, 1, 1));
    add_row(0, DEF_SYM_BYTES, 0, 1, 0, 0, 1,
            typed_plan(0, CLS_ENHANCE, DEF_SYM_BYTES, 1, 0, 2, 2));
    add_row(0, DEF_SYM_BYTES + 1, 0, 0, 0, 0, 1,
            typed_plan(0, CLS_PRED, DEF_SYM_BYTES, 2, 0, 3, 3));
    add_row(0, LEN_MAX, 0, 0, 0, 0, 0, '0);
    add_row(0, META_BYTES, 0, 0, 1, PARITY_MAX, 0, '0);
    add_row(0, META_BYTES, 0, 1, 1, 5, 0, '0);
    // full and over-range rates, override after an oversize drop
    add_row(1, LEN_MAX, 1, 0, 0, 0, 0, '0);
    add_row(1, 10 * DEF_SYM_BYTES, 0, 0, 0, 0, 0, '0);
    add_row(1, 100 * DEF_SYM_BYTES, 0, 1, 0, 0, 0, '0);
    add_row(1, 200 * DEF_SYM_BYTES, 0, 1, 1, 0, 0, '0);
    add_row(1, 200 * DEF_SYM_BYTES, 1, 0, 1, 3, 0, '0);
    // jumbo mtu guard edges
    add_row(2, 15 * DEF_SYM_BYTES + 1, 0, 0, 0, 0, 0, '0);
    add_row(2, 15 * DEF_SYM_BYTES + 1, 0, 1, 0, 0, 0, '0);
    add_row(2, 15 * DEF_SYM_BYTES + 1, 1, 0, 1, 40, 0, '0);
    add_row(2, 15 * DEF_SYM_BYTES, 0, 0, 0, 0, 0, '0);
    // repair disabled, source count at and past its limit
    add_row(3, LEN_MAX, 0, 0, 0, 0, 1, typed_plan(1, CLS_IDR, 0, 0, 0, 0, 0));
    add_row(3, 21 * 65535, 0, 0, 1, PARITY_MAX, 0, '0);
    add_row(3, 21 * 65535 + 1, 1, 0, 0, 0, 1, typed_plan(1, CLS_IDR, 0, 0, 0, 0, 0));
    // one-byte symbols, floor forcing oversize, zero enhance rate
    add_row(4, META_BYTES, 0, 0, 0, 0, 0, '0);
    add_row(4, META_BYTES, 0, 1, 0, 0, 0, '0);
    // largest symbols, override clamped at full capacity
    add_row(5, LEN_MAX, 0, 0, 1, PARITY_MAX, 0, '0);
    add_row(5, META_BYTES, 1, 0, 0, 0, 0, '0);

    cur_cfg       = profiles[0];
    blocks_issued = '0;
    next_seq      = '0;
    cur_prof      = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].prof != cur_prof) begin
        settle();
        apply_settings(profiles[directed_rows[i].prof]);
        cur_prof = directed_rows[i].prof;
      end
      push_frame(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      apply_settings(random_settings());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_frame(random_frame(), 1'b0, '0);
        if ($urandom_range(0, 99) == 0) settle();
      end
    end

    settle();
    $display("covered %0d frames under %0d register settings", n_frames, n_settings);
    $display("results: %0d malformed, %0d oversize, %0d guard-raised; %0d overrides offered",
             n_malformed, n_oversize, n_guard, n_override);
    if (n_errors == 0)
      $display("tb_fec_block_planner_unit: done, clean");
    else
      $display("tb_fec_block_planner_unit: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/fbp_pkg.sv
src/fbp_cfg_regs.sv
src/fbp_ctrl.sv
src/fbp_datapath.sv
src/fec_block_planner_unit.sv
verif/tb_fec_block_planner_unit.sv
